@@ hdl/image_border_pad_replicate_core_assert.svh @@
// Assertion macros shared by the padding core RTL.
// Included by image_border_pad_replicate_core; no other dependencies.
`ifndef IMAGE_BORDER_PAD_REPLICATE_CORE_ASSERT_SVH
`define IMAGE_BORDER_PAD_REPLICATE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define IBPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ibpr: implication check failed");
// next-cycle implication
`define IBPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ibpr: next-cycle check failed");
`else
`define IBPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IBPR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ibpr_pkg.sv @@
// Shared types, constants and helpers for the image border padding core.
// No dependencies; used by every other RTL file but the assert header.
`default_nettype none
package ibpr_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int MAX_PLANES = 8;
	localparam int MAX_PAD    = 16;

	localparam int PIX_W   = 32;
	localparam int CRD_W   = 7;   // coordinate and size field width
	localparam int PAD_W   = 6;
	localparam int PLN_W   = 3;   // plane field width
	localparam int CFG_W   = 7;   // widest register
	localparam int IDX_W   = 3;
	localparam int AX_W    = 9;   // signed working width of the axis maths
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int PLANE_W = $clog2(MAX_PLANES);
	localparam int ADDR_W  = PLANE_W + ROW_W + COL_W;
	localparam int DEPTH   = MAX_PLANES * MAX_ROWS * MAX_COLS;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_ROWS = 3'd0,
		REG_IMAGE_COLS = 3'd1,
		REG_PAD_TOP    = 3'd2,
		REG_PAD_BOTTOM = 3'd3,
		REG_PAD_LEFT   = 3'd4,
		REG_PAD_RIGHT  = 3'd5,
		REG_PAD_MODE   = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		PAD_ZERO = 1'b0,
		PAD_REPL = 1'b1
	} pad_mode_t;

	// saturated configuration
	typedef struct packed {
		logic [CRD_W-1:0]        rows;
		logic [CRD_W-1:0]        cols;
		logic signed [PAD_W-1:0] pad_top;
		logic signed [PAD_W-1:0] pad_bottom;
		logic signed [PAD_W-1:0] pad_left;
		logic signed [PAD_W-1:0] pad_right;
		logic                    repl;
	} cfg_t;

	// one axis mapped to the source image
	typedef struct packed {
		logic             bad;   // outside padded extent
		logic             keep;  // maps to a stored pixel
		logic [CRD_W-1:0] src;
	} axis_t;

	localparam cfg_t CFG_RESET = '{
		rows:       CRD_W'(MAX_ROWS),
		cols:       CRD_W'(MAX_COLS),
		pad_top:    '0,
		pad_bottom: '0,
		pad_left:   '0,
		pad_right:  '0,
		repl:       1'b1
	};

	function automatic logic [CRD_W-1:0] sat_size(input logic [CRD_W-1:0] v,
			input logic [CRD_W-1:0] max_v);
		logic [CRD_W-1:0] r;
		r = v;
		if (v == '0)
			r = CRD_W'(1);
		else if (v > max_v)
			r = max_v;
		return r;
	endfunction

	function automatic logic signed [PAD_W-1:0] sat_pad(input logic [PAD_W-1:0] v);
		logic signed [PAD_W-1:0] s;
		logic signed [PAD_W-1:0] r;
		s = $signed(v);
		r = s;
		if (s < -PAD_W'(MAX_PAD))
			r = -PAD_W'(MAX_PAD);
		else if (s > PAD_W'(MAX_PAD))
			r = PAD_W'(MAX_PAD);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/ibpr_cfg.sv @@
// Configuration register file of the padding core; sizes and pads are
// saturated as they are written. Depends on ibpr_pkg.
`default_nettype none
module ibpr_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ibpr_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [ibpr_pkg::CFG_W-1:0]  cfg_data,
	output ibpr_pkg::cfg_t                   cfg
);

	ibpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ibpr_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (ibpr_pkg::cfg_reg_t'(cfg_index))
				ibpr_pkg::REG_IMAGE_ROWS: cfg_q.rows <= ibpr_pkg::sat_size(cfg_data,
					ibpr_pkg::CRD_W'(ibpr_pkg::MAX_ROWS));
				ibpr_pkg::REG_IMAGE_COLS: cfg_q.cols <= ibpr_pkg::sat_size(cfg_data,
					ibpr_pkg::CRD_W'(ibpr_pkg::MAX_COLS));
				ibpr_pkg::REG_PAD_TOP:    cfg_q.pad_top <=
					ibpr_pkg::sat_pad(cfg_data[ibpr_pkg::PAD_W-1:0]);
				ibpr_pkg::REG_PAD_BOTTOM: cfg_q.pad_bottom <=
					ibpr_pkg::sat_pad(cfg_data[ibpr_pkg::PAD_W-1:0]);
				ibpr_pkg::REG_PAD_LEFT:   cfg_q.pad_left <=
					ibpr_pkg::sat_pad(cfg_data[ibpr_pkg::PAD_W-1:0]);
				ibpr_pkg::REG_PAD_RIGHT:  cfg_q.pad_right <=
					ibpr_pkg::sat_pad(cfg_data[ibpr_pkg::PAD_W-1:0]);
				ibpr_pkg::REG_PAD_MODE:   cfg_q.repl <= (cfg_data[0] == ibpr_pkg::PAD_REPL);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ hdl/ibpr_axis.sv @@
// Two-stage mapping of one padded coordinate onto the kept source range.
// Depends on ibpr_pkg.
`default_nettype none
module ibpr_axis (
	input  wire logic                              clk,
	input  wire logic                              adv,
	input  wire logic [ibpr_pkg::CRD_W-1:0]        p,
	input  wire logic [ibpr_pkg::CRD_W-1:0]        size,
	input  wire logic signed [ibpr_pkg::PAD_W-1:0] lead,
	input  wire logic signed [ibpr_pkg::PAD_W-1:0] trail,
	input  wire logic                              repl,
	output ibpr_pkg::axis_t                        res
);

	localparam int W = ibpr_pkg::AX_W;

	logic signed [W-1:0] p_x, size_x, lead_x, trail_x;
	logic signed [W-1:0] lo_c, hi_c, s_c, ext_c, crop_c;
	logic signed [W-1:0] s_s1, lo_s1, hi_s1;
	logic                bad_s1;
	logic                below, above, empty;
	logic signed [W-1:0] src_c;
	ibpr_pkg::axis_t     res_c, res_s2;

	// stage 1: shift into source space, find the kept bounds and check the extent
	always_comb begin
		p_x     = $signed({2'b00, p});
		size_x  = $signed({2'b00, size});
		lead_x  = W'(lead);
		trail_x = W'(trail);
		lo_c    = (lead_x < 0) ? -lead_x : '0;
		crop_c  = (trail_x < 0) ? -trail_x : '0;
		hi_c    = size_x - crop_c - W'(1);
		s_c     = p_x - lead_x;
		ext_c   = size_x + lead_x + trail_x;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1   <= s_c;
			lo_s1  <= lo_c;
			hi_s1  <= hi_c;
			bad_s1 <= (p_x >= ext_c);
		end
	end

	// stage 2: clamp to the nearest kept edge
	always_comb begin
		below      = s_s1 < lo_s1;
		above      = s_s1 > hi_s1;
		empty      = lo_s1 > hi_s1;
		src_c      = below ? lo_s1 : (above ? hi_s1 : s_s1);
		res_c.bad  = bad_s1;
		res_c.keep = !empty && (repl || (!below && !above));
		res_c.src  = src_c[ibpr_pkg::CRD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_c;
	end

	assign res = res_s2;

endmodule
`default_nettype wire

@@ hdl/ibpr_store.sv @@
// Single-port pixel store, all planes, with registered read data.
// Depends on ibpr_pkg.
`default_nettype none
module ibpr_store (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic                         we,
	input  wire logic [ibpr_pkg::ADDR_W-1:0]  addr,
	input  wire logic [ibpr_pkg::PIX_W-1:0]   wdata,
	output logic [ibpr_pkg::PIX_W-1:0]        rdata
);

	logic [ibpr_pkg::PIX_W-1:0] mem [ibpr_pkg::DEPTH];
	logic [ibpr_pkg::PIX_W-1:0] rdata_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			rdata_s3 <= mem[addr];
		end
	end

	assign rdata = rdata_s3;

endmodule
`default_nettype wire

@@ hdl/image_border_pad_replicate_core.sv @@
// Image border padding core: a 32768 x 32-bit pixel store (8 planes of
// 64 x 64) with replicate or zero-fill border reads. One item per clock is
// accepted, and the pipeline only halts while a result is held by out_stall.
// Writes and reads go through one single-port memory in item order, so a read
// always sees every earlier write. The store is not cleared at reset and
// needs no start-up pass. The user writes configuration only while the core
// is idle; the core does not check.
// Depends on ibpr_pkg, ibpr_cfg, ibpr_axis, ibpr_store and the assert header.
`default_nettype none
`include "image_border_pad_replicate_core_assert.svh"
module image_border_pad_replicate_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ibpr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [ibpr_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         func,
	input  wire logic [ibpr_pkg::PLN_W-1:0]   plane,
	input  wire logic [ibpr_pkg::CRD_W-1:0]   row,
	input  wire logic [ibpr_pkg::CRD_W-1:0]   col,
	input  wire logic [ibpr_pkg::PIX_W-1:0]   pixel_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ibpr_pkg::PIX_W-1:0]        pixel_out,
	output logic                              bad_address
);

	localparam int ROW_W   = ibpr_pkg::ROW_W;
	localparam int COL_W   = ibpr_pkg::COL_W;
	localparam int PLANE_W = ibpr_pkg::PLANE_W;

	ibpr_pkg::cfg_t  cfg;
	ibpr_pkg::axis_t r_res, c_res;

	logic adv;
	logic read_go;

	logic                        v_s1, func_s1, pln_bad_s1, wr_ok_s1;
	logic [PLANE_W-1:0]          plane_s1;
	logic [ROW_W-1:0]            row_s1;
	logic [COL_W-1:0]            col_s1;
	logic [ibpr_pkg::PIX_W-1:0]  pix_s1;

	logic                        v_s2, func_s2, pln_bad_s2, wr_ok_s2;
	logic [PLANE_W-1:0]          plane_s2;
	logic [ROW_W-1:0]            row_s2;
	logic [COL_W-1:0]            col_s2;
	logic [ibpr_pkg::PIX_W-1:0]  pix_s2;

	logic                        v_s3, bad_s3, zero_s3;
	logic [ibpr_pkg::PIX_W-1:0]  rdata;
	logic [ibpr_pkg::ADDR_W-1:0] addr;
	logic                        we;
	logic                        pln_bad_c, wr_ok_c;

	ibpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// whole pipeline moves unless a finished result is held
	assign adv      = !(v_s3 && out_stall);
	assign in_stall = !adv;

	assign pln_bad_c = !(int'(plane) < ibpr_pkg::MAX_PLANES);
	assign wr_ok_c   = !pln_bad_c && (row < cfg.rows) && (col < cfg.cols);

	ibpr_axis u_row (
		.clk   (clk),
		.adv   (adv),
		.p     (row),
		.size  (cfg.rows),
		.lead  (cfg.pad_top),
		.trail (cfg.pad_bottom),
		.repl  (cfg.repl),
		.res   (r_res)
	);

	ibpr_axis u_col (
		.clk   (clk),
		.adv   (adv),
		.p     (col),
		.size  (cfg.cols),
		.lead  (cfg.pad_left),
		.trail (cfg.pad_right),
		.repl  (cfg.repl),
		.res   (c_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= read_go;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1    <= func;
			plane_s1   <= plane[PLANE_W-1:0];
			pln_bad_s1 <= pln_bad_c;
			wr_ok_s1   <= wr_ok_c;
			row_s1     <= row[ROW_W-1:0];
			col_s1     <= col[COL_W-1:0];
			pix_s1     <= pixel_in;

			func_s2    <= func_s1;
			plane_s2   <= plane_s1;
			pln_bad_s2 <= pln_bad_s1;
			wr_ok_s2   <= wr_ok_s1;
			row_s2     <= row_s1;
			col_s2     <= col_s1;
			pix_s2     <= pix_s1;

			bad_s3     <= pln_bad_s2 || r_res.bad || c_res.bad;
			zero_s3    <= !(r_res.keep && c_res.keep);
		end
	end

	assign read_go = v_s2 && (func_s2 == ibpr_pkg::FUNC_READ);
	assign we      = v_s2 && (func_s2 == ibpr_pkg::FUNC_WRITE) && wr_ok_s2;
	assign addr    = (func_s2 == ibpr_pkg::FUNC_WRITE) ?
		{plane_s2, row_s2, col_s2} :
		{plane_s2, r_res.src[ROW_W-1:0], c_res.src[COL_W-1:0]};

	ibpr_store u_store (
		.clk   (clk),
		.en    (adv),
		.we    (we),
		.addr  (addr),
		.wdata (pix_s2),
		.rdata (rdata)
	);

	assign out_valid   = v_s3;
	assign bad_address = bad_s3;
	assign pixel_out   = (bad_s3 || zero_s3) ? '0 : rdata;

	`IBPR_ASSERT_IMP(a_bad_zero, clk, arst_n, out_valid && bad_address, pixel_out == '0)
	`IBPR_ASSERT_IMP(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall)
	`IBPR_ASSERT_NXT(a_read_only_out, clk, arst_n, adv, out_valid == $past(read_go))

endmodule
`default_nettype wire

@@ tb/sv/tb_pad_pkg.sv @@
// Padded-image geometry shared by the padding core testbench files.
// Depends on ibpr_pkg for widths and codes; used by the checker and tb_top.
package tb_pad_pkg;
	import ibpr_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;   // unmapped register index

	// register contents as written, before saturation
	typedef struct packed {
		logic [CRD_W-1:0] rows;
		logic [CRD_W-1:0] cols;
		logic [PAD_W-1:0] top;
		logic [PAD_W-1:0] bottom;
		logic [PAD_W-1:0] left;
		logic [PAD_W-1:0] right;
		logic             repl;
	} pad_regs_t;

	localparam pad_regs_t PAD_REGS_RESET = '{
		rows:   7'd64,
		cols:   7'd64,
		top:    '0,
		bottom: '0,
		left:   '0,
		right:  '0,
		repl:   PAD_REPL
	};

	function automatic pad_regs_t write_reg(pad_regs_t r, logic [IDX_W-1:0] idx,
			logic [CFG_W-1:0] d);
		pad_regs_t n;
		n = r;
		case (idx)
			REG_IMAGE_ROWS: n.rows   = d;
			REG_IMAGE_COLS: n.cols   = d;
			REG_PAD_TOP:    n.top    = d[PAD_W-1:0];
			REG_PAD_BOTTOM: n.bottom = d[PAD_W-1:0];
			REG_PAD_LEFT:   n.left   = d[PAD_W-1:0];
			REG_PAD_RIGHT:  n.right  = d[PAD_W-1:0];
			REG_PAD_MODE:   n.repl   = d[0];
			default: ;
		endcase
		return n;
	endfunction

	function automatic int size_of(logic [CRD_W-1:0] v, int max_v);
		int s;
		s = int'(v);
		if (s < 1)
			s = 1;
		else if (s > max_v)
			s = max_v;
		return s;
	endfunction

	function automatic int pad_of(logic [PAD_W-1:0] v);
		int p;
		p = int'(v);
		if (v[PAD_W-1])
			p = p - (1 << PAD_W);
		if (p < -MAX_PAD)
			p = -MAX_PAD;
		else if (p > MAX_PAD)
			p = MAX_PAD;
		return p;
	endfunction

	function automatic bit in_source(pad_regs_t r, logic [CRD_W-1:0] rw,
			logic [CRD_W-1:0] cl);
		return int'(rw) < size_of(r.rows, MAX_ROWS) && int'(cl) < size_of(r.cols, MAX_COLS);
	endfunction

	// One axis: false for a zero-filled border or when the crop keeps no line.
	function automatic bit map_line(int p, int size, int lead, int trail, bit repl,
			output int src);
		int lo;
		int hi;
		int s;
		lo  = (lead < 0) ? -lead : 0;
		hi  = size - ((trail < 0) ? -trail : 0) - 1;
		s   = p - lead;
		src = 0;
		if (lo > hi)
			return 1'b0;
		if (s >= lo && s <= hi) begin
			src = s;
			return 1'b1;
		end
		if (!repl)
			return 1'b0;
		src = (s < lo) ? lo : hi;
		return 1'b1;
	endfunction

	// Padded coordinate to store address; hit is set when a stored word is read.
	function automatic void locate(pad_regs_t r, logic [PLN_W-1:0] pl,
			logic [CRD_W-1:0] rw, logic [CRD_W-1:0] cl,
			output bit bad, output bit hit, output logic [ADDR_W-1:0] addr);
		int rows;
		int cols;
		int sr;
		int sc;
		bit hr;
		bit hc;
		rows = size_of(r.rows, MAX_ROWS);
		cols = size_of(r.cols, MAX_COLS);
		bad  = int'(rw) >= rows + pad_of(r.top) + pad_of(r.bottom) ||
			int'(cl) >= cols + pad_of(r.left) + pad_of(r.right);
		hit  = 1'b0;
		addr = '0;
		if (!bad) begin
			hr  = map_line(int'(rw), rows, pad_of(r.top), pad_of(r.bottom), r.repl, sr);
			hc  = map_line(int'(cl), cols, pad_of(r.left), pad_of(r.right), r.repl, sc);
			hit = hr && hc;
			if (hit)
				addr = {pl, sr[ROW_W-1:0], sc[COL_W-1:0]};
		end
	endfunction

endpackage

@@ tb/sv/pad_read_checker.sv @@
// Checker for the padding core: mirrors the pixel store and settings, predicts
// each read result and compares it with the output channel. Uses tb_pad_pkg.
module pad_read_checker
	import ibpr_pkg::*, tb_pad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              func,
	input  logic [PLN_W-1:0]  plane,
	input  logic [CRD_W-1:0]  row,
	input  logic [CRD_W-1:0]  col,
	input  logic [PIX_W-1:0]  pixel_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PIX_W-1:0]  pixel_out,
	input  logic              bad_address,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             bad;
	} read_result_t;

	read_result_t     reads_due [$];
	logic [PIX_W-1:0] frame [0:DEPTH-1];
	pad_regs_t        regs;

	always @(posedge clk or negedge arst_n) begin : watch
		read_result_t     want;
		bit               bad;
		bit               hit;
		logic [ADDR_W-1:0] addr;
		if (!arst_n) begin
			regs = PAD_REGS_RESET;
			reads_due.delete();
			errors = 0;
		end else begin
			if (cfg_we)
				regs = write_reg(regs, cfg_index, cfg_data);
			// retire before predicting, so a same-edge transfer cannot look unexpected
			if (out_valid && !out_stall) begin
				if (reads_due.size() == 0) begin
					errors++;
					$error("result transfer with no read outstanding: pixel_out %h", pixel_out);
				end else begin
					want = reads_due.pop_front();
					if (pixel_out !== want.pixel) begin
						errors++;
						$error("pixel_out: expected %h, got %h", want.pixel, pixel_out);
					end
					if (bad_address !== want.bad) begin
						errors++;
						$error("bad_address: expected %b, got %b", want.bad, bad_address);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_WRITE) begin
					if (in_source(regs, row, col))
						frame[{plane, row[ROW_W-1:0], col[COL_W-1:0]}] = pixel_in;
				end else begin
					locate(regs, plane, row, col, bad, hit, addr);
					want.bad   = bad;
					want.pixel = hit ? frame[addr] : '0;
					reads_due.push_back(want);
				end
			end
		end
		pending = reads_due.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the padding core testbench: clock, reset, settings, pixel transfers
// and the verdict. Depends on ibpr_pkg, tb_pad_pkg and pad_read_checker.
module tb_top;
	import ibpr_pkg::*;
	import tb_pad_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             func;
	logic [PLN_W-1:0] plane;
	logic [CRD_W-1:0] row;
	logic [CRD_W-1:0] col;
	logic [PIX_W-1:0] pixel_in;
	logic             out_valid;
	logic             out_stall;
	logic [PIX_W-1:0] pixel_out;
	logic             bad_address;
	int               errors;
	int               pending;

	pad_regs_t regs;                  // settings last written to the core
	bit        filled [0:DEPTH-1];    // store words that hold a written pixel
	bit        calm;                  // no idling on either side
	int        hold_req;              // bumped to ask for a long output hold-off
	int        n_reads;
	int        n_writes;
	int        n_settings;

	image_border_pad_replicate_core DUT (.*);
	pad_read_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		#(12 * 500000);
		$display("tb_top: errors");
		$finish;
	end

	// output side: random stalls, plus a long counted hold-off on request
	initial begin : receiver
		int left;
		int served;
		left      = 0;
		served    = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_req) begin
				served = hold_req;
				left   = 400;
			end
			if (left > 0) begin
				left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 29);
			end
		end
	end

	task automatic put_item(logic f, logic [PLN_W-1:0] p, logic [CRD_W-1:0] r,
			logic [CRD_W-1:0] c, logic [PIX_W-1:0] d);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		plane    <= p;
		row      <= r;
		col      <= c;
		pixel_in <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (f == FUNC_WRITE) begin
			if (in_source(regs, r, c))
				filled[{p, r[ROW_W-1:0], c[COL_W-1:0]}] = 1'b1;
			n_writes++;
		end else begin
			n_reads++;
		end
	endtask

	// a source word that would be read unwritten gets its own write transfer first
	task automatic read_px(logic [PLN_W-1:0] p, logic [CRD_W-1:0] r, logic [CRD_W-1:0] c);
		bit                bad;
		bit                hit;
		logic [ADDR_W-1:0] a;
		locate(regs, p, r, c, bad, hit, a);
		if (hit && !filled[a])
			put_item(FUNC_WRITE, a[ADDR_W-1 -: PLN_W], CRD_W'(a[ROW_W+COL_W-1 -: ROW_W]),
				CRD_W'(a[COL_W-1:0]), $urandom);
		put_item(FUNC_READ, p, r, c, $urandom);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_regs(pad_regs_t n);
		logic [IDX_W-1:0] k;
		drain();
		for (int i = 0; i <= REG_NONE; i++) begin
			k = IDX_W'(i);
			cfg_we    <= 1'b1;
			cfg_index <= k;
			case (k)
				REG_IMAGE_ROWS: cfg_data <= n.rows;
				REG_IMAGE_COLS: cfg_data <= n.cols;
				REG_PAD_TOP:    cfg_data <= {1'($urandom), n.top};
				REG_PAD_BOTTOM: cfg_data <= {1'($urandom), n.bottom};
				REG_PAD_LEFT:   cfg_data <= {1'($urandom), n.left};
				REG_PAD_RIGHT:  cfg_data <= {1'($urandom), n.right};
				REG_PAD_MODE:   cfg_data <= {6'($urandom), n.repl};
				default:        cfg_data <= CFG_W'($urandom);
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		regs = n;
		n_settings++;
	endtask

	function automatic pad_regs_t geometry(int rs, int cs, int t, int b, int l, int r, bit m);
		pad_regs_t n;
		n.rows   = CRD_W'(rs);
		n.cols   = CRD_W'(cs);
		n.top    = PAD_W'(t);
		n.bottom = PAD_W'(b);
		n.left   = PAD_W'(l);
		n.right  = PAD_W'(r);
		n.repl   = m;
		return n;
	endfunction

	function automatic logic [CRD_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return CRD_W'(1);
			1: return CRD_W'(MAX_ROWS);
			2: return CRD_W'($urandom_range(127));   // zero and oversize saturate
			3, 4, 5: return CRD_W'($urandom_range(1, 12));
			default: return CRD_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [PAD_W-1:0] pick_pad();
		case ($urandom_range(9))
			0: return PAD_W'(-MAX_PAD);
			1: return PAD_W'(MAX_PAD);
			2: return PAD_W'($urandom);
			3: return '0;
			default: return PAD_W'(int'($urandom_range(32)) - 16);
		endcase
	endfunction

	function automatic pad_regs_t random_regs();
		pad_regs_t n;
		n.rows   = pick_size();
		n.cols   = pick_size();
		n.top    = pick_pad();
		n.bottom = pick_pad();
		n.left   = pick_pad();
		n.right  = pick_pad();
		n.repl   = 1'($urandom_range(1));
		return n;
	endfunction

	// count takes in every transfer, fill-in and dropped writes too
	task automatic random_items(int count);
		int rows;
		int cols;
		int er;
		int ec;
		int start;
		int v;
		logic [CRD_W-1:0] r;
		logic [CRD_W-1:0] c;
		rows  = size_of(regs.rows, MAX_ROWS);
		cols  = size_of(regs.cols, MAX_COLS);
		er    = rows + pad_of(regs.top) + pad_of(regs.bottom);
		ec    = cols + pad_of(regs.left) + pad_of(regs.right);
		start = n_reads + n_writes;
		while (n_reads + n_writes - start < count) begin
			v = $urandom_range(19);
			if (v < 9) begin
				put_item(FUNC_WRITE, PLN_W'($urandom), CRD_W'($urandom_range(rows - 1)),
					CRD_W'($urandom_range(cols - 1)), $urandom);
			end else if (v == 9) begin
				r = CRD_W'($urandom);
				c = CRD_W'($urandom);
				put_item(FUNC_WRITE, PLN_W'($urandom), r, c, $urandom);
			end else if (v < 19 && er > 0 && ec > 0) begin
				read_px(PLN_W'($urandom), CRD_W'($urandom_range(er - 1)),
					CRD_W'($urandom_range(ec - 1)));
			end else begin
				read_px(PLN_W'($urandom), CRD_W'($urandom), CRD_W'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int guard;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		func       = FUNC_WRITE;
		plane      = '0;
		row        = '0;
		col        = '0;
		pixel_in   = '0;
		calm       = 1'b0;
		hold_req   = 0;
		n_reads    = 0;
		n_writes   = 0;
		n_settings = 0;
		regs       = PAD_REGS_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: corner words, dropped writes, reads past the edge
		put_item(FUNC_WRITE, 3'd7, 7'd63, 7'd63, 32'hFFFF_FFFF);
		put_item(FUNC_WRITE, 3'd0, 7'd0, 7'd0, 32'h0000_0000);
		put_item(FUNC_WRITE, 3'd3, 7'd64, 7'd5, 32'hDEAD_BEEF);
		put_item(FUNC_WRITE, 3'd3, 7'd5, 7'd127, 32'h1234_5678);
		read_px(3'd7, 7'd63, 7'd63);
		read_px(3'd0, 7'd0, 7'd0);
		read_px(3'd7, 7'd64, 7'd0);
		read_px(3'd0, 7'd0, 7'd127);

		// widest extent, replicated then zero-filled corners
		apply_regs(geometry(64, 64, 16, 16, 16, 16, PAD_REPL));
		read_px(3'd7, 7'd95, 7'd95);
		read_px(3'd0, 7'd0, 7'd0);
		read_px(3'd2, 7'd0, 7'd95);
		read_px(3'd2, 7'd96, 7'd10);
		apply_regs(geometry(64, 64, 16, 16, 16, 16, PAD_ZERO));
		read_px(3'd7, 7'd95, 7'd95);
		read_px(3'd1, 7'd15, 7'd40);
		read_px(3'd1, 7'd16, 7'd16);

		// crop wider than the image, but the extent is still non-empty
		apply_regs(geometry(10, 10, -12, 16, 0, 0, PAD_REPL));
		read_px(3'd4, 7'd3, 7'd3);
		// padded extent collapses
		apply_regs(geometry(1, 1, -16, -16, -16, -16, PAD_REPL));
		read_px(3'd5, 7'd0, 7'd0);
		// out-of-range sizes and pads saturate
		apply_regs(geometry(0, 127, -32, 31, -17, 17, PAD_ZERO));
		read_px(3'd6, 7'd0, 7'd0);
		read_px(3'd6, 7'd20, 7'd70);

		for (int ph = 0; ph < 12; ph++) begin
			apply_regs(random_regs());
			calm = (ph == 1);
			if (ph == 3)
				hold_req++;   // core fills up and stalls its input
			random_items(60);
			if (ph == 6)
				drain();
			random_items(60);
		end

		in_valid <= 1'b0;
		calm = 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (pending != 0)
			$error("%0d read results never arrived", pending);
		$display("summary: %0d reads, %0d writes over %0d settings (zero fill, replicate,",
			n_reads, n_writes, n_settings);
		$display("summary: crops, empty extents, saturated registers, long output hold-off)");
		if (errors == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
